### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// cond implies expr in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

`endif

### rtl/core/cac_pkg.sv
// ----------------------------------------------------------------------------
// cac_pkg
// Types, constants and helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cac_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int WORD_BITS    = 32;
	localparam int ANGLE_BITS   = 30;
	localparam int DIV_STEPS    = 34;
	localparam int DIV_LO_BITS  = DIV_STEPS - FRAC_BITS;
	localparam int SQRT_STEPS   = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int NUM_CELLS    = DIV_STEPS;
	localparam int CW           = 36;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4,
		OP_MAG = 3'd5,
		OP_ARG = 3'd6
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// atan(2^-i) in Q30, truncated
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		op_t                   op;
		logic [31:0]           fix_re;
		logic [31:0]           fix_im;
		logic                  fix_eq;
		logic [1:0]            fix_st;
		logic                  azero;
		logic                  bzero;
		logic                  dneg_re;
		logic                  dneg_im;
		logic                  dovf_re;
		logic                  dovf_im;
		logic [63:0]           den;
		logic [63:0]           dr_re;
		logic [63:0]           dr_im;
		logic [DIV_LO_BITS-1:0] nlo_re;
		logic [DIV_LO_BITS-1:0] nlo_im;
		logic [DIV_STEPS-1:0]  dq_re;
		logic [DIV_STEPS-1:0]  dq_im;
		logic [63:0]           sq_s;
		logic [63:0]           sq_res;
		logic [CW-1:0]         cx;
		logic [CW-1:0]         cy;
		logic [CW-1:0]         cz;
	} cac_data_t;

	// sign and magnitude to a saturated word: {saturated, value}
	function automatic logic [32:0] sat_word(input logic neg, input logic [63:0] m);
		logic [63:0] lim;
		lim = 64'd1 << (WORD_BITS - 1);
		if (neg) begin
			if (m > lim)
				return {1'b1, 32'h8000_0000};
			return {1'b0, 32'(~m + 64'd1)};
		end
		if (m > lim - 64'd1)
			return {1'b1, 32'h7FFF_FFFF};
		return {1'b0, m[31:0]};
	endfunction

endpackage

### rtl/core/cac_prep.sv
// ----------------------------------------------------------------------------
// cac_prep
// Operand register, products, sums of products and cell chain seeding.
// ----------------------------------------------------------------------------
module cac_prep import cac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  logic [2:0]         operation,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               vld_out,
	output cac_data_t          d_out
);

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	op_t                op_s1, op_s2, op_s3;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;

	logic signed [63:0] p_arbr_s2, p_aibi_s2, p_arbi_s2, p_aibr_s2;
	logic signed [63:0] p_brbr_s2, p_bibi_s2, p_arar_s2, p_aiai_s2;
	logic [31:0]        fre_s2, fim_s2, fre_s3, fim_s3;
	logic               feq_s2, feq_s3;
	logic [1:0]         fst_s2, fst_s3;
	logic               az_s2, bz_s2, az_s3, bz_s3;
	logic [CW-1:0]      cx_s2, cy_s2, cz_s2, cx_s3, cy_s3, cz_s3;

	logic signed [65:0] mre_s3, mim_s3, nre_s3, nim_s3;
	logic [63:0]        den_s3, sq_s3;

	logic signed [32:0] sum_re, sum_im;
	logic [31:0]        fre, fim;
	logic               feq;
	logic [1:0]         fst;
	logic signed [CW-1:0] cx0, cy0, cz0;

	logic [65:0] mre_a, mim_a, nre_a, nim_a;
	logic [63:0] mre_m, mim_m, nre_m, nim_m;
	logic [32:0] mul_re, mul_im;
	cac_data_t   d_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op_t'(operation);
		ar_s1 <= a_re;
		ai_s1 <= a_im;
		br_s1 <= b_re;
		bi_s1 <= b_im;
	end

	always_comb begin
		if (op_s1 == OP_SUB) begin
			sum_re = 33'(ar_s1) - 33'(br_s1);
			sum_im = 33'(ai_s1) - 33'(bi_s1);
		end else begin
			sum_re = 33'(ar_s1) + 33'(br_s1);
			sum_im = 33'(ai_s1) + 33'(bi_s1);
		end
		fre = '0;
		fim = '0;
		feq = 1'b0;
		fst = ST_OK;
		case (op_s1) inside
			OP_ADD, OP_SUB: begin
				fre = (sum_re[32] != sum_re[31]) ?
					(sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_re[31:0];
				fim = (sum_im[32] != sum_im[31]) ?
					(sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_im[31:0];
				if ((sum_re[32] != sum_re[31]) || (sum_im[32] != sum_im[31]))
					fst = ST_SAT;
			end
			OP_EQ: feq = (ar_s1 == br_s1) && (ai_s1 == bi_s1);
			default: ;
		endcase
		// quadrant fold for the vectoring rotation
		cx0 = CW'(ar_s1);
		cy0 = CW'(ai_s1);
		cz0 = '0;
		if (ar_s1 < 0) begin
			if (ai_s1 >= 0) begin
				cx0 = CW'(ai_s1);
				cy0 = -CW'(ar_s1);
				cz0 = CW'({ATAN_TAB[0], 1'b0});
			end else begin
				cx0 = -CW'(ai_s1);
				cy0 = CW'(ar_s1);
				cz0 = -CW'({ATAN_TAB[0], 1'b0});
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s2     <= op_s1;
		p_arbr_s2 <= ar_s1 * br_s1;
		p_aibi_s2 <= ai_s1 * bi_s1;
		p_arbi_s2 <= ar_s1 * bi_s1;
		p_aibr_s2 <= ai_s1 * br_s1;
		p_brbr_s2 <= br_s1 * br_s1;
		p_bibi_s2 <= bi_s1 * bi_s1;
		p_arar_s2 <= ar_s1 * ar_s1;
		p_aiai_s2 <= ai_s1 * ai_s1;
		fre_s2    <= fre;
		fim_s2    <= fim;
		feq_s2    <= feq;
		fst_s2    <= fst;
		az_s2     <= (ar_s1 == 0) && (ai_s1 == 0);
		bz_s2     <= (br_s1 == 0) && (bi_s1 == 0);
		cx_s2     <= cx0;
		cy_s2     <= cy0;
		cz_s2     <= cz0;
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		mre_s3 <= 66'(p_arbr_s2) - 66'(p_aibi_s2);
		mim_s3 <= 66'(p_arbi_s2) + 66'(p_aibr_s2);
		nre_s3 <= 66'(p_arbr_s2) + 66'(p_aibi_s2);
		nim_s3 <= 66'(p_aibr_s2) - 66'(p_arbi_s2);
		den_s3 <= $unsigned(p_brbr_s2) + $unsigned(p_bibi_s2);
		sq_s3  <= $unsigned(p_arar_s2) + $unsigned(p_aiai_s2);
		fre_s3 <= fre_s2;
		fim_s3 <= fim_s2;
		feq_s3 <= feq_s2;
		fst_s3 <= fst_s2;
		az_s3  <= az_s2;
		bz_s3  <= bz_s2;
		cx_s3  <= cx_s2;
		cy_s3  <= cy_s2;
		cz_s3  <= cz_s2;
	end

	always_comb begin
		mre_a = mre_s3[65] ? -mre_s3 : mre_s3;
		mim_a = mim_s3[65] ? -mim_s3 : mim_s3;
		nre_a = nre_s3[65] ? -nre_s3 : nre_s3;
		nim_a = nim_s3[65] ? -nim_s3 : nim_s3;
		mre_m = mre_a[63:0];
		mim_m = mim_a[63:0];
		nre_m = nre_a[63:0];
		nim_m = nim_a[63:0];
		mul_re = sat_word(mre_s3[65], (mre_m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		mul_im = sat_word(mim_s3[65], (mim_m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);

		d_nxt.op     = op_s3;
		d_nxt.fix_re = fre_s3;
		d_nxt.fix_im = fim_s3;
		d_nxt.fix_eq = feq_s3;
		d_nxt.fix_st = fst_s3;
		if (op_s3 == OP_MUL) begin
			d_nxt.fix_re = mul_re[31:0];
			d_nxt.fix_im = mul_im[31:0];
			d_nxt.fix_st = (mul_re[32] || mul_im[32]) ? ST_SAT : ST_OK;
		end
		d_nxt.azero   = az_s3;
		d_nxt.bzero   = bz_s3;
		d_nxt.dneg_re = nre_s3[65];
		d_nxt.dneg_im = nim_s3[65];
		d_nxt.dovf_re = (nre_m >> DIV_LO_BITS) >= den_s3;
		d_nxt.dovf_im = (nim_m >> DIV_LO_BITS) >= den_s3;
		d_nxt.den     = den_s3;
		d_nxt.dr_re   = nre_m >> DIV_LO_BITS;
		d_nxt.dr_im   = nim_m >> DIV_LO_BITS;
		d_nxt.nlo_re  = nre_m[DIV_LO_BITS-1:0];
		d_nxt.nlo_im  = nim_m[DIV_LO_BITS-1:0];
		d_nxt.dq_re   = '0;
		d_nxt.dq_im   = '0;
		d_nxt.sq_s    = sq_s3;
		d_nxt.sq_res  = '0;
		d_nxt.cx      = cx_s3;
		d_nxt.cy      = cy_s3;
		d_nxt.cz      = cz_s3;
	end

	always_ff @(posedge clk) begin
		d_out <= d_nxt;
	end

	assign vld_out = vld_s4;

endmodule

### rtl/core/cac_cell.sv
// ----------------------------------------------------------------------------
// cac_cell
// One step of restoring division, square root and vectoring rotation.
// ----------------------------------------------------------------------------
module cac_cell import cac_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld_in,
	input  cac_data_t d_in,
	output logic      vld_out,
	output cac_data_t d_out
);

	localparam bit HAS_BIT = IDX < DIV_LO_BITS;
	localparam int BIT_POS = HAS_BIT ? DIV_LO_BITS - 1 - IDX : 0;
	localparam int SQ_SH   = (IDX < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
	localparam int AT_IDX  = (IDX < CORDIC_STEPS) ? IDX : 0;

	function automatic logic [64:0] div_step(input logic [63:0] r, input logic [63:0] den,
		input logic b);
		logic [64:0] t;
		t = {r, b};
		if (t >= {1'b0, den})
			return {1'b1, 64'(t - {1'b0, den})};
		return {1'b0, t[63:0]};
	endfunction

	logic                 vld_q;
	cac_data_t            d_q, nxt;
	logic [64:0]          st_re, st_im;
	logic [63:0]          sq_bit, sq_try;
	logic signed [CW-1:0] x, y, z, dx, dy, at;

	always_comb begin
		nxt = d_in;
		st_re = div_step(d_in.dr_re, d_in.den, HAS_BIT ? d_in.nlo_re[BIT_POS] : 1'b0);
		st_im = div_step(d_in.dr_im, d_in.den, HAS_BIT ? d_in.nlo_im[BIT_POS] : 1'b0);
		if (IDX < DIV_STEPS) begin
			nxt.dr_re = st_re[63:0];
			nxt.dr_im = st_im[63:0];
			nxt.dq_re = {d_in.dq_re[DIV_STEPS-2:0], st_re[64]};
			nxt.dq_im = {d_in.dq_im[DIV_STEPS-2:0], st_im[64]};
		end

		sq_bit = 64'd1 << SQ_SH;
		sq_try = d_in.sq_res + sq_bit;
		if (IDX < SQRT_STEPS) begin
			if (d_in.sq_s >= sq_try) begin
				nxt.sq_s   = d_in.sq_s - sq_try;
				nxt.sq_res = (d_in.sq_res >> 1) + sq_bit;
			end else begin
				nxt.sq_res = d_in.sq_res >> 1;
			end
		end

		x  = $signed(d_in.cx);
		y  = $signed(d_in.cy);
		z  = $signed(d_in.cz);
		dx = y >>> AT_IDX;
		dy = x >>> AT_IDX;
		at = $signed(CW'(ATAN_TAB[AT_IDX]));
		if (IDX < CORDIC_STEPS) begin
			if (y >= 0) begin
				nxt.cx = x + dx;
				nxt.cy = y - dy;
				nxt.cz = z + at;
			end else begin
				nxt.cx = x - dx;
				nxt.cy = y + dy;
				nxt.cz = z - at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign vld_out = vld_q;
	assign d_out   = d_q;

endmodule

### rtl/core/cac_post.sv
// ----------------------------------------------------------------------------
// cac_post
// Rounding, saturation and result selection at the end of the cell chain.
// ----------------------------------------------------------------------------
module cac_post import cac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_in,
	input  cac_data_t   d_in,
	output logic        done,
	output logic [31:0] res_re,
	output logic [31:0] res_im,
	output logic        equal_flag,
	output logic [1:0]  status
);

	function automatic logic [32:0] div_fin(input logic neg, input logic ovf,
		input logic [DIV_STEPS-1:0] q, input logic [63:0] r, input logic [63:0] den);
		logic        big;
		logic [34:0] q2;
		big = ovf || ({1'b0, q} > (35'd1 << (WORD_BITS - 1)));
		q2  = {1'b0, q} + {34'd0, (r >= den - r)};
		if (big)
			return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
		return sat_word(neg, 64'(q2));
	endfunction

	logic        done_q, eq_q;
	logic [31:0] re_q, im_q;
	logic [1:0]  st_q;

	logic [32:0]   dv_re, dv_im, sq_w, ang_w;
	logic [63:0]   sq_r;
	logic [CW-1:0] zm, zr;
	logic [31:0]   o_re, o_im;
	logic          o_eq;
	logic [1:0]    o_st;

	always_comb begin
		dv_re = div_fin(d_in.dneg_re, d_in.dovf_re, d_in.dq_re, d_in.dr_re, d_in.den);
		dv_im = div_fin(d_in.dneg_im, d_in.dovf_im, d_in.dq_im, d_in.dr_im, d_in.den);
		sq_r  = d_in.sq_res + {63'd0, (d_in.sq_s > d_in.sq_res)};
		sq_w  = sat_word(1'b0, sq_r);
		zm    = d_in.cz[CW-1] ? -d_in.cz : d_in.cz;
		zr    = (zm + (CW'(1) << (ANGLE_BITS - FRAC_BITS - 1))) >> (ANGLE_BITS - FRAC_BITS);
		ang_w = sat_word(d_in.cz[CW-1], 64'(zr));

		o_re = d_in.fix_re;
		o_im = d_in.fix_im;
		o_eq = d_in.fix_eq;
		o_st = d_in.fix_st;
		case (d_in.op)
			OP_DIV: begin
				if (d_in.bzero) begin
					o_re = '0;
					o_im = '0;
					o_st = ST_DIVZ;
				end else begin
					o_re = dv_re[31:0];
					o_im = dv_im[31:0];
					o_st = (dv_re[32] || dv_im[32]) ? ST_SAT : ST_OK;
				end
			end
			OP_MAG: begin
				o_re = sq_w[31:0];
				o_im = '0;
				o_st = sq_w[32] ? ST_SAT : ST_OK;
			end
			OP_ARG: begin
				o_im = '0;
				if (d_in.azero) begin
					o_re = '0;
					o_st = ST_OK;
				end else begin
					o_re = ang_w[31:0];
					o_st = ang_w[32] ? ST_SAT : ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		re_q <= o_re;
		im_q <= o_im;
		eq_q <= o_eq;
		st_q <= o_st;
	end

	assign done       = done_q;
	assign res_re     = re_q;
	assign res_im     = im_q;
	assign equal_flag = eq_q;
	assign status     = st_q;

endmodule

### rtl/core/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex ALU in signed Q16.16: add, sub, mul, div, equal,
// magnitude and argument, with saturation and status.
//
//   channel   handshake        payload
//   command   start / busy     operation, a_re, a_im, b_re, b_im
//   result    done (strobe)    res_re, res_im, equal_flag, status
//
// One transaction accepted per cycle; busy stays low.
// The pipeline: four prep stages, a chain of 34 cells (a quotient bit in each,
// a root digit in the first 32, a rotation in the first 30), one output stage.
// Reset clears the valid bits of the pipeline; operand data is not reset.
// done pulses for one cycle per transaction; the receiver cannot stall.
// ----------------------------------------------------------------------------
module complex_arith_unit import cac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic               equal_flag,
	output logic [1:0]         status
);

	logic [NUM_CELLS:0] v_chain;
	cac_data_t          d_chain [NUM_CELLS+1];

	assign busy = 1'b0;

	cac_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (start && !busy),
		.operation (operation),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.vld_out   (v_chain[0]),
		.d_out     (d_chain[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		cac_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (v_chain[i]),
			.d_in    (d_chain[i]),
			.vld_out (v_chain[i+1]),
			.d_out   (d_chain[i+1])
		);
	end

	cac_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_in     (v_chain[NUM_CELLS]),
		.d_in       (d_chain[NUM_CELLS]),
		.done       (done),
		.res_re     (res_re),
		.res_im     (res_im),
		.equal_flag (equal_flag),
		.status     (status)
	);

endmodule

### rtl/core/cac_checker.sv
// ----------------------------------------------------------------------------
// cac_checker
// Port-level checks on both channels of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cac_checker import cac_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] res_re,
	input logic [31:0] res_im,
	input logic        equal_flag,
	input logic [1:0]  status
);

	`ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy, "unit stalled a transaction")
	`ASSERT_IMPLIES(a_start_taken, clk, arst_n, start, !busy, "start not taken")
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, done,
		(status == ST_OK || status == ST_DIVZ || status == ST_SAT), "bad status code")
	`ASSERT_IMPLIES(a_divz_clean, clk, arst_n, done && status == ST_DIVZ,
		res_re == 32'd0 && res_im == 32'd0 && !equal_flag, "div by zero result not clear")
	`ASSERT_IMPLIES(a_eq_clean, clk, arst_n, done && equal_flag,
		status == ST_OK && res_re == 32'd0 && res_im == 32'd0, "equal result not clear")

endmodule

bind complex_arith_unit cac_checker u_cac_checker (.*);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for complex_arith_unit. Directed corner transactions,
// then random ones over all operations. A bit-exact predictor covers add,
// sub, mul, div, equal, magnitude and argument, with saturation and status.
// Results are matched in order against the predicted queue.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cac_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int N_RANDOM = 1450;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] ar, ai, br, bi;
	} cmd_t;

	typedef struct {
		logic signed [31:0] re, im;
		logic               eq;
		logic [1:0]         st;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         operation = '0;
	logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic               done;
	logic signed [31:0] res_re, res_im;
	logic               equal_flag;
	logic [1:0]         status;

	cmd_t     pending_cmds[$];
	outcome_t expected_results[$];
	int       errors = 0;
	int       sent = 0;
	int       checked = 0;
	int       stall_cycles = 0;
	int       n_sat = 0, n_divz = 0, n_eq = 0;
	bit       cmd_taken = 0;

	complex_arith_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic logic [63:0] abs_mag(input longint v, output bit neg);
		neg = v < 0;
		return neg ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp_word(input bit neg, input logic [63:0] m, inout bit sat);
		logic [63:0] lim;
		lim = 64'd1 << (WORD_BITS - 1);
		if (neg) begin
			if (m > lim) begin
				sat = 1;
				m = lim;
			end
			return -longint'(m);
		end
		if (m > lim - 1) begin
			sat = 1;
			m = lim - 1;
		end
		return longint'(m);
	endfunction

	function automatic logic [63:0] round_off(input logic [63:0] m, input int s);
		return (m + (64'd1 << (s - 1))) >> s;
	endfunction

	// p*q +/- r*s, exact, as sign and magnitude
	function automatic logic [63:0] cross_sum(input longint p, q, r, s, input bit subtract,
			output bit neg);
		bit np, nq, nr, ns, n1, n2;
		logic [63:0] m1, m2;
		m1 = abs_mag(p, np) * abs_mag(q, nq);
		m2 = abs_mag(r, nr) * abs_mag(s, ns);
		n1 = (np != nq) && m1 != 0;
		n2 = ((nr != ns) != subtract) && m2 != 0;
		if (n1 == n2) begin
			neg = n1 && (m1 + m2) != 0;
			return m1 + m2;
		end
		if (m1 >= m2) begin
			neg = n1 && m1 != m2;
			return m1 - m2;
		end
		neg = n2;
		return m2 - m1;
	endfunction

	function automatic logic [63:0] fixed_quotient(input logic [63:0] num, den);
		logic [63:0] cap, r, q, b;
		bit big;
		cap = 64'd1 << (WORD_BITS - 1);
		r = 0;
		q = 0;
		big = 0;
		for (int i = 63 + FRAC_BITS; i >= 0; i--) begin
			b = (i >= FRAC_BITS) ? ((num >> (i - FRAC_BITS)) & 64'd1) : 64'd0;
			r = (r << 1) | b;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
			if (q > cap) begin
				big = 1;
				q = cap + 1;
			end
		end
		if (!big && r >= den - r)
			q++;
		return q;
	endfunction

	function automatic logic [63:0] root_rounded(input logic [63:0] s);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return (s > res) ? res + 1 : res;
	endfunction

	function automatic longint vector_angle(input longint x, y);
		longint z, t, dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 2 * longint'(ATAN_TAB[0]);
			end else begin
				x = -y;
				y = t;
				z = -2 * longint'(ATAN_TAB[0]);
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += longint'(ATAN_TAB[i]);
			end else begin
				x -= dx;
				y += dy;
				z -= longint'(ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic outcome_t complex_result(input cmd_t c);
		outcome_t o;
		longint ar, ai, br, bi, rr, ri;
		bit sat, neg, neg2;
		logic [63:0] m, q, den;
		ar = longint'(c.ar);
		ai = longint'(c.ai);
		br = longint'(c.br);
		bi = longint'(c.bi);
		rr = 0;
		ri = 0;
		sat = 0;
		o.eq = 0;
		o.st = ST_OK;
		case (c.op) inside
			OP_ADD, OP_SUB: begin
				m = abs_mag((c.op == OP_SUB) ? ar - br : ar + br, neg);
				rr = clamp_word(neg, m, sat);
				m = abs_mag((c.op == OP_SUB) ? ai - bi : ai + bi, neg);
				ri = clamp_word(neg, m, sat);
			end
			OP_MUL: begin
				m = cross_sum(ar, br, ai, bi, 1, neg);
				rr = clamp_word(neg, round_off(m, FRAC_BITS), sat);
				m = cross_sum(ar, bi, ai, br, 0, neg);
				ri = clamp_word(neg, round_off(m, FRAC_BITS), sat);
			end
			OP_DIV: begin
				if (br == 0 && bi == 0) begin
					o.st = ST_DIVZ;
				end else begin
					den = cross_sum(br, br, bi, bi, 0, neg);
					m = cross_sum(ar, br, ai, bi, 0, neg);
					q = fixed_quotient(m, den);
					rr = clamp_word(neg && q != 0, q, sat);
					m = cross_sum(ai, br, ar, bi, 1, neg2);
					q = fixed_quotient(m, den);
					ri = clamp_word(neg2 && q != 0, q, sat);
				end
			end
			OP_EQ: o.eq = (ar == br && ai == bi);
			OP_MAG: begin
				m = cross_sum(ar, ar, ai, ai, 0, neg);
				rr = clamp_word(0, root_rounded(m), sat);
			end
			OP_ARG: begin
				m = abs_mag(vector_angle(ar, ai), neg);
				m = round_off(m, ANGLE_BITS - FRAC_BITS);
				rr = clamp_word(neg && m != 0, m, sat);
			end
			default: ;
		endcase
		if (sat)
			o.st = ST_SAT;
		o.re = rr[31:0];
		o.im = ri[31:0];
		return o;
	endfunction

	// ---------------- stimulus ----------------
	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 0;
			3: return $signed($urandom_range(0, 2 * 32'h0010_0000)) - 32'sh0010_0000;
			4: return 32'sd1 <<< $urandom_range(0, 31);
			5: return -($signed($urandom_range(1, 32'h00FF_FFFF)));
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_cmd(input logic [2:0] op, input logic signed [31:0] ar, ai, br, bi);
		cmd_t c;
		c.op = op;
		c.ar = ar;
		c.ai = ai;
		c.br = br;
		c.bi = bi;
		pending_cmds.push_back(c);
	endtask

	task automatic load_directed();
		queue_cmd(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		queue_cmd(OP_ADD, 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 32'sh0000_0001);
		queue_cmd(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, -32'sh0000_0001);
		queue_cmd(OP_SUB, 0, 0, 32'sh8000_0000, 0);
		queue_cmd(OP_MUL, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, -32'sh0001_0000);
		queue_cmd(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		queue_cmd(OP_MUL, 32'sh0000_8000, 0, 32'sh0000_0001, 0);
		queue_cmd(OP_MUL, -32'sh0000_8000, 0, 32'sh0000_0001, 0);
		queue_cmd(OP_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0);
		queue_cmd(OP_DIV, 32'sh0003_0000, 32'sh0004_0000, 0, 32'sh0002_0000);
		queue_cmd(OP_DIV, 32'sh0001_0000, 0, 32'sh0003_0000, 0);
		queue_cmd(OP_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 0);
		queue_cmd(OP_DIV, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh8000_0000);
		queue_cmd(OP_EQ, 32'sh1234_5678, -32'sh0000_0001, 32'sh1234_5678, -32'sh0000_0001);
		queue_cmd(OP_EQ, 32'sh1234_5678, 0, 32'sh1234_5678, 32'sh0000_0001);
		queue_cmd(OP_MAG, 32'sh0003_0000, 32'sh0004_0000, 0, 0);
		queue_cmd(OP_MAG, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
		queue_cmd(OP_MAG, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		queue_cmd(OP_ARG, 0, 0, 32'sh7FFF_FFFF, 0);
		queue_cmd(OP_ARG, -32'sh0001_0000, 0, 0, 0);
		queue_cmd(OP_ARG, -32'sh0001_0000, -32'sh0000_0001, 0, 0);
		queue_cmd(OP_ARG, 0, 32'sh8000_0000, 0, 0);
		queue_cmd(OP_ARG, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
		queue_cmd(OP_UNUSED, 32'sh7FFF_FFFF, -32'sh0000_0001, 32'sh8000_0000, 32'sh0000_0001);
	endtask

	task automatic load_random();
		logic [2:0] op;
		logic signed [31:0] ar, ai, br, bi;
		for (int n = 0; n < N_RANDOM; n++) begin
			op = ($urandom_range(0, 40) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
			ar = pick_operand();
			ai = pick_operand();
			br = pick_operand();
			bi = pick_operand();
			if (op == OP_EQ && $urandom_range(0, 1)) begin
				br = ar;
				bi = ai;
				if ($urandom_range(0, 2) == 0)
					bi = bi ^ (32'sd1 <<< $urandom_range(0, 31));
			end
			if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
				br = 0;
				if ($urandom_range(0, 1))
					bi = 0;
			end
			queue_cmd(op, ar, ai, br, bi);
		end
	endtask

	// ---------------- driver ----------------
	function automatic bit sender_idles();
		int total;
		total = 25 + N_RANDOM;
		if (sent < total / 3)
			return $urandom_range(0, 99) < 24;
		if (sent < 2 * total / 3)
			return $urandom_range(0, 99) < 75;
		return 0;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken)
				void'(pending_cmds.pop_front());
			cmd_taken = 0;
			if (pending_cmds.size() > 0 && !sender_idles()) begin
				start     <= 1'b1;
				operation <= pending_cmds[0].op;
				a_re      <= pending_cmds[0].ar;
				a_im      <= pending_cmds[0].ai;
				b_re      <= pending_cmds[0].br;
				b_im      <= pending_cmds[0].bi;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	task automatic report_mismatch(input string field, input logic [31:0] want, got);
		$display("mismatch #%0d: %s expected %h got %h", checked, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n) begin
			stall_cycles++;
			if (start && !busy) begin
				exp_o = complex_result(pending_cmds[0]);
				expected_results.push_back(exp_o);
				cmd_taken = 1;
				sent++;
				stall_cycles = 0;
				if (exp_o.st == ST_SAT)
					n_sat++;
				if (exp_o.st == ST_DIVZ)
					n_divz++;
				if (exp_o.eq)
					n_eq++;
			end
			if (done) begin
				stall_cycles = 0;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected done", 32'd0, 32'd1);
				end else begin
					exp_o = expected_results.pop_front();
					if (res_re !== exp_o.re)
						report_mismatch("res_re", exp_o.re, res_re);
					if (res_im !== exp_o.im)
						report_mismatch("res_im", exp_o.im, res_im);
					if (equal_flag !== exp_o.eq)
						report_mismatch("equal_flag", 32'(exp_o.eq), 32'(equal_flag));
					if (status !== exp_o.st)
						report_mismatch("status", 32'(exp_o.st), 32'(status));
				end
				checked++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		load_directed();
		load_random();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_cmds.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d transactions checked over all operation codes and operand extremes",
			checked);
		$display("%0d saturated, %0d divide-by-zero, %0d equal", n_sat, n_divz, n_eq);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cac_pkg.sv
rtl/core/cac_prep.sv
rtl/core/cac_cell.sv
rtl/core/cac_post.sv
rtl/core/complex_arith_unit.sv
rtl/core/cac_checker.sv
verif/testbench.sv
